// ----- sv/cftr_pkg.sv -----
// Shared types and constants of the CAN frame trace ring.
package cftr_pkg;

   // Command codes carried in the request tuser.
   typedef enum logic [1:0] {
      CMD_APPEND   = 2'd0,
      CMD_SNAPSHOT = 2'd1,
      CMD_SINCE    = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // Field widths.
   localparam int SEQ_W    = 63;
   localparam int HDR_W    = 51;
   localparam int DATA_W   = 64;
   localparam int REQ_W    = 256;
   localparam int RSP_W    = 240;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;

   // One ring entry: sequence, header, payload, timestamp from the low bit up.
   localparam int ENTRY_W  = SEQ_W + HDR_W + DATA_W + DATA_W;
   localparam int HDR_LO   = SEQ_W;
   localparam int PAY_LO   = HDR_LO + HDR_W;
   localparam int TS_LO    = PAY_LO + DATA_W;

   // Register addresses.
   localparam logic [CSR_AW-1:0] REG_FIRST_SEQUENCE = 4'd0;

endpackage

// ----- sv/cftr_ram.sv -----
// Simple dual-port synchronous RAM with registered read.
module cftr_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/can_frame_trace_ring.sv -----
// Top level of the CAN frame trace ring: ring control, walk and reply sequencer.
//
//  Channel  Direction  Word
//  req_     in         tuser command, tdata frame and snapshot query
//  rsp_     out        tuser frame_valid, tdata returned frame, tlast end of reply
//  csr_     in/out     APB register first_sequence at byte address 0
//
// An append is one write into the entry memory.
// A snapshot walks the ring with a memory read, then a compare, for each entry
// visited, then sends each kept word by a pick stack read, an entry memory read
// and the word's capture into the output register, plus any stall on rsp_.
// No request is taken until the last word of a reply is delivered.
// Reset is synchronous; the memories need no clearing, only entries already
// written are ever visited.
module can_frame_trace_ring #(
   parameter int RING_DEPTH = 1024,
   parameter int MAX_REPLY  = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // tuser: command[1:0]
   // tdata: device[3:0] channel[7:4] frame_flags[14:8] can_id[43:15]
   //        data_length[50:44] payload[114:51] timestamp[178:115]
   //        match_any_device[179] match_any_channel[180]
   //        since_sequence[243:181] max_frames[250:244]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,
   input  logic [cftr_pkg::REQ_W-1:0]  req_tdata,
   // tuser: frame_valid
   // tdata: out_channel[3:0] out_flags[10:4] out_can_id[39:11]
   //        out_length[46:40] out_payload[110:47] out_timestamp[174:111]
   //        latest_delivered[237:175]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tuser,
   output logic [cftr_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cftr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cftr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cftr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int NW = $clog2(MAX_REPLY + 1);
   localparam int SD = (MAX_REPLY > 1) ? MAX_REPLY : 2;
   localparam int SW = $clog2(SD);
   localparam int SEQ_W = cftr_pkg::SEQ_W;

   localparam logic [CW:0]   DEPTH_SUM  = (CW + 1)'(RING_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT  = CW'(RING_DEPTH);
   localparam logic [AW-1:0] DEPTH_LAST = AW'(RING_DEPTH - 1);
   localparam logic [6:0]    REPLY_CAP  = 7'(MAX_REPLY);

   typedef enum logic [2:0] {
      S_IDLE, S_WALK_RD, S_WALK_EVAL, S_WALK_DONE,
      S_POP_RD, S_POP_MEM, S_POP_DATA, S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SEQ_W-1:0]       next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0]       first_seq_ff, first_seq_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          walk_i_ff, walk_i_in;
   logic [NW-1:0]          pick_n_ff, pick_n_in;
   logic [NW-1:0]          limit_ff, limit_in;
   logic [SW-1:0]          pop_j_ff, pop_j_in;
   logic [3:0]             dev_ff, dev_in;
   logic [3:0]             chn_ff, chn_in;
   logic                   any_dev_ff, any_dev_in;
   logic                   any_chn_ff, any_chn_in;
   logic                   since_mode_ff, since_mode_in;
   logic [SEQ_W-1:0]       since_ff, since_in;
   logic [SEQ_W-1:0]       latest_ff, latest_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [cftr_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW:0]            slot_sum;
   logic [AW-1:0]          slot_mod;
   logic [AW-1:0]          newest_ptr;
   logic                   ring_we;
   logic [AW-1:0]          ring_waddr;
   logic [AW-1:0]          ring_raddr;
   logic [cftr_pkg::ENTRY_W-1:0] ring_wdata, ring_rdata;
   logic                   stack_we;
   logic [AW-1:0]          stack_rdata;
   logic [SEQ_W-1:0]       ent_seq;
   logic [cftr_pkg::HDR_W-1:0] ent_hdr;
   logic                   ent_match;
   logic                   req_fire;
   logic                   csr_write;
   logic [SEQ_W-1:0]       csr_seq;
   cftr_pkg::cmd_type      req_cmd;

   assign req_cmd   = cftr_pkg::cmd_type'(req_tuser);
   assign req_fire  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr == cftr_pkg::REG_FIRST_SEQUENCE);
   assign csr_seq   = (csr_pwdata[SEQ_W-1:0] == '0) ? SEQ_W'(1) : csr_pwdata[SEQ_W-1:0];

   // Slot after the newest entry and the newest entry itself, modulo the depth.
   always_comb begin
      slot_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      if (slot_sum >= DEPTH_SUM) begin
         slot_sum = slot_sum - DEPTH_SUM;
      end
      slot_mod   = slot_sum[AW-1:0];
      newest_ptr = (slot_mod == '0) ? DEPTH_LAST : slot_mod - AW'(1);
   end

   // Entry fields on the memory read port and the filter match.
   assign ent_seq   = ring_rdata[SEQ_W-1:0];
   assign ent_hdr   = ring_rdata[cftr_pkg::HDR_LO +: cftr_pkg::HDR_W];
   assign ent_match = (any_dev_ff || (ent_hdr[3:0] == dev_ff))
                      && (any_chn_ff || (ent_hdr[7:4] == chn_ff));

   // Memory ports.
   assign ring_we    = req_fire && (req_cmd == cftr_pkg::CMD_APPEND);
   assign ring_waddr = (count_ff == DEPTH_CNT) ? head_ff : slot_mod;
   assign ring_wdata = {req_tdata[178:115], req_tdata[114:51], req_tdata[50:0], next_seq_ff};
   assign ring_raddr = (state_ff == S_POP_MEM) ? stack_rdata : ptr_ff;
   assign stack_we   = (state_ff == S_WALK_EVAL)
                       && !(since_mode_ff && (ent_seq <= since_ff)) && ent_match;

   // Next-state logic of the ring control and the reply sequencer.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      next_seq_in   = next_seq_ff;
      first_seq_in  = first_seq_ff;
      ptr_in        = ptr_ff;
      walk_i_in     = walk_i_ff;
      pick_n_in     = pick_n_ff;
      limit_in      = limit_ff;
      pop_j_in      = pop_j_ff;
      dev_in        = dev_ff;
      chn_in        = chn_ff;
      any_dev_in    = any_dev_ff;
      any_chn_in    = any_chn_ff;
      since_mode_in = since_mode_ff;
      since_in      = since_ff;
      latest_in     = latest_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_write) begin
         first_seq_in = csr_seq;
         next_seq_in  = csr_seq;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_cmd)
                  cftr_pkg::CMD_APPEND: begin
                     if (count_ff == DEPTH_CNT) begin
                        head_in = (head_ff == DEPTH_LAST) ? '0 : head_ff + AW'(1);
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                     next_seq_in = next_seq_ff + SEQ_W'(1);
                  end
                  cftr_pkg::CMD_SNAPSHOT, cftr_pkg::CMD_SINCE: begin
                     dev_in        = req_tdata[3:0];
                     chn_in        = req_tdata[7:4];
                     any_dev_in    = req_tdata[179];
                     any_chn_in    = req_tdata[180];
                     since_mode_in = (req_cmd == cftr_pkg::CMD_SINCE);
                     since_in      = req_tdata[243:181];
                     latest_in     = (req_cmd == cftr_pkg::CMD_SINCE) ? req_tdata[243:181]
                                                                      : '0;
                     limit_in      = (req_tdata[250:244] > REPLY_CAP) ? NW'(MAX_REPLY)
                                                                      : req_tdata[244 +: NW];
                     ptr_in        = newest_ptr;
                     walk_i_in     = '0;
                     pick_n_in     = '0;
                     state_in      = S_WALK_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK_RD: begin
            if ((walk_i_ff < count_ff) && (pick_n_ff < limit_ff)) begin
               state_in = S_WALK_EVAL;
            end else begin
               state_in = S_WALK_DONE;
            end
         end
         S_WALK_EVAL: begin
            if (since_mode_ff && (ent_seq <= since_ff)) begin
               state_in = S_WALK_DONE;
            end else begin
               if (ent_match) begin
                  pick_n_in = pick_n_ff + NW'(1);
                  if (ent_seq > latest_ff) begin
                     latest_in = ent_seq;
                  end
               end
               walk_i_in = walk_i_ff + CW'(1);
               ptr_in    = (ptr_ff == '0) ? DEPTH_LAST : ptr_ff - AW'(1);
               state_in  = S_WALK_RD;
            end
         end
         S_WALK_DONE: begin
            if (pick_n_ff == '0) begin
               // Empty reply: one word with no frame.
               rsp_valid_in = 1'b1;
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {2'b00, latest_ff, 175'd0};
               state_in     = S_OUT;
            end else begin
               pop_j_in = SW'(pick_n_ff - NW'(1));
               state_in = S_POP_RD;
            end
         end
         S_POP_RD: begin
            state_in = S_POP_MEM;
         end
         S_POP_MEM: begin
            state_in = S_POP_DATA;
         end
         S_POP_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_user_in  = 1'b1;
            rsp_last_in  = (pop_j_ff == '0);
            rsp_data_in  = {2'b00, latest_ff,
                            ring_rdata[cftr_pkg::TS_LO +: 64],
                            ring_rdata[cftr_pkg::PAY_LO +: 64],
                            ent_hdr[50:4]};
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  pop_j_in = pop_j_ff - SW'(1);
                  state_in = S_POP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         next_seq_ff  <= SEQ_W'(1);
         first_seq_ff <= SEQ_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         first_seq_ff <= first_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      walk_i_ff     <= walk_i_in;
      pick_n_ff     <= pick_n_in;
      limit_ff      <= limit_in;
      pop_j_ff      <= pop_j_in;
      dev_ff        <= dev_in;
      chn_ff        <= chn_in;
      any_dev_ff    <= any_dev_in;
      any_chn_ff    <= any_chn_in;
      since_mode_ff <= since_mode_in;
      since_ff      <= since_in;
      latest_ff     <= latest_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Entry memory.
   cftr_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (cftr_pkg::ENTRY_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Stack of kept slots, popped newest kept last so the reply runs oldest first.
   cftr_ram #(
      .DEPTH (SD),
      .WIDTH (AW)
   ) u_pick (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (pick_n_ff[SW-1:0]),
      .wr_data (ptr_ff),
      .rd_addr (pop_j_ff),
      .rd_data (stack_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == cftr_pkg::REG_FIRST_SEQUENCE) ? {1'b0, first_seq_ff}
                                                                   : '0;

endmodule
